>>> rtl/core/pca_pkg.sv
// Shared types and constants for the pixel color adjust block.
package pca_pkg;

    localparam int GAIN_FRAC_BITS_DEF = 8;
    localparam int MODE_W             = 5;
    localparam int GAIN_W             = 16;
    localparam int CFG_W              = 16;

    // Register indexes on the configuration port
    localparam logic CFG_IDX_MODE = 1'b0;
    localparam logic CFG_IDX_GAIN = 1'b1;

    // Adjust modes
    localparam logic [MODE_W-1:0] M_GREY      = 5'd0;
    localparam logic [MODE_W-1:0] M_BRIGHT    = 5'd1;
    localparam logic [MODE_W-1:0] M_CON_ALL   = 5'd2;
    localparam logic [MODE_W-1:0] M_CON_R     = 5'd3;
    localparam logic [MODE_W-1:0] M_CON_G     = 5'd4;
    localparam logic [MODE_W-1:0] M_CON_B     = 5'd5;
    localparam logic [MODE_W-1:0] M_CON_M     = 5'd6;
    localparam logic [MODE_W-1:0] M_CON_Y     = 5'd7;
    localparam logic [MODE_W-1:0] M_CON_C     = 5'd8;
    localparam logic [MODE_W-1:0] M_SAT_ALL   = 5'd9;
    localparam logic [MODE_W-1:0] M_SAT_B     = 5'd10;
    localparam logic [MODE_W-1:0] M_SAT_G     = 5'd11;
    localparam logic [MODE_W-1:0] M_SAT_R     = 5'd12;
    localparam logic [MODE_W-1:0] M_SAT_M     = 5'd13;
    localparam logic [MODE_W-1:0] M_SAT_Y     = 5'd14;
    localparam logic [MODE_W-1:0] M_SAT_C     = 5'd15;
    localparam logic [MODE_W-1:0] M_LUM_B     = 5'd16;
    localparam logic [MODE_W-1:0] M_LUM_G     = 5'd17;
    localparam logic [MODE_W-1:0] M_LUM_R     = 5'd18;
    localparam logic [MODE_W-1:0] M_LUM_M     = 5'd19;
    localparam logic [MODE_W-1:0] M_LUM_Y     = 5'd20;
    localparam logic [MODE_W-1:0] M_LUM_C     = 5'd21;

    localparam logic [MODE_W-1:0] MODE_RST = M_GREY;
    localparam logic [GAIN_W-1:0] GAIN_RST = 16'd256;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] alpha;
    } t_pix_in;

    typedef struct packed {
        logic [7:0] red_out;
        logic [7:0] green_out;
        logic [7:0] blue_out;
        logic [7:0] alpha_out;
    } t_pix_out;

endpackage

>>> rtl/core/pixel_color_adjust.sv
// Top level of the pixel color adjust block: RGBA pixel in, adjusted pixel out.
// Pipeline: two register stages (input register, then result register); o_valid
// rises once the result register has been loaded from the input register.
// Throughput: one pixel per cycle; the block stalls upstream only while both
// registers are full and the output side stalls.
// Reset: synchronous, active low; clears both valid flags and loads mode 0
// (grey) and gain 256 (1.0 at eight fraction bits).
module pixel_color_adjust #(
    parameter int GAIN_FRAC_BITS = pca_pkg::GAIN_FRAC_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic                  i_cfg_idx,
    input  logic [pca_pkg::CFG_W-1:0] i_cfg_data,
    input  logic                  i_valid,
    output logic                  o_stall,
    input  pca_pkg::t_pix_in      i_pix,
    output logic                  o_valid,
    input  logic                  i_stall,
    output pca_pkg::t_pix_out     o_pix
);
    import pca_pkg::*;

    // Wide enough for a << F plus a 11 x 16 product with headroom
    localparam int NW  = GAIN_FRAC_BITS + 28;
    localparam logic signed [NW-1:0] RND = NW'((64'sd1 <<< GAIN_FRAC_BITS) - 1);

    logic [MODE_W-1:0]        r_mode;
    logic signed [GAIN_W-1:0] r_gain;
    logic     r_v1, r_v2;
    t_pix_in  r_in;
    t_pix_out r_out, n_out;
    logic     adv1, adv2;

    // Advance the result register when empty or taken; advance input likewise
    assign adv2    = !r_v2 || !i_stall;
    assign adv1    = !r_v1 || adv2;
    assign o_stall = !adv1;
    assign o_valid = r_v2;
    assign o_pix   = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_RST;
            r_gain <= GAIN_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_IDX_MODE: r_mode <= i_cfg_data[MODE_W-1:0];
                CFG_IDX_GAIN: r_gain <= i_cfg_data[GAIN_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            if (adv1) r_v1 <= i_valid;
            if (adv2) r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv1 && i_valid) r_in  <= i_pix;
        if (adv2 && r_v1)    r_out <= n_out;
    end

    // a + x*gain/2^F, truncated toward zero
    function automatic logic signed [NW-1:0] scaled(input logic signed [10:0] a,
                                                   input logic signed [10:0] x,
                                                   input logic signed [GAIN_W-1:0] g);
        logic signed [NW-1:0] num;
        logic signed [26:0]   prod;
        prod = 27'(x) * 27'(g);
        num = (NW'(a) <<< GAIN_FRAC_BITS) + NW'(prod);
        if (num < 0) num = num + RND;
        return num >>> GAIN_FRAC_BITS;
    endfunction

    function automatic logic [7:0] clamp8(input logic signed [NW-1:0] v);
        if (v < 0)              return 8'd0;
        else if (v > NW'(255))  return 8'd255;
        else                    return v[7:0];
    endfunction

    logic [9:0]  sum;
    logic [20:0] avg_mul;
    logic signed [10:0] cr, cg, cb, av, pa_v, pb_v, mn;
    logic signed [10:0] xa0, xa1, xa2, ax0, ax1, ax2;
    logic signed [NW-1:0] s0, s1, s2, lum_r, lum_g, lum_b, ms;
    logic dom_r, dom_g, dom_b;
    logic [1:0] pair;

    always_comb begin
        sum     = 10'(r_in.red) + 10'(r_in.green) + 10'(r_in.blue);
        // floor(sum/3) for sum up to 765
        avg_mul = 21'(sum) * 21'd683;
        av      = 11'(avg_mul[20:11]);
        cr = 11'(r_in.red);
        cg = 11'(r_in.green);
        cb = 11'(r_in.blue);
        dom_r = (cr >= cg) && (cr >= cb);
        dom_g = (cg >= cb) && (cg >= cr);
        dom_b = (cb >= cr) && (cb >= cg);

        // Pair for secondary modes: 0 magenta (r,b), 1 yellow (r,g), 2 cyan (g,b)
        case (r_mode)
            M_CON_Y, M_SAT_Y, M_LUM_Y: pair = 2'd1;
            M_CON_C, M_SAT_C, M_LUM_C: pair = 2'd2;
            default:                   pair = 2'd0;
        endcase
        case (pair)
            2'd1:    begin pa_v = cr; pb_v = cg; end
            2'd2:    begin pa_v = cg; pb_v = cb; end
            default: begin pa_v = cr; pb_v = cb; end
        endcase
        mn = (pa_v < pb_v) ? pa_v : pb_v;

        // Lane operands
        ax1 = 11'sd128; xa1 = cg - 11'sd128;
        ax2 = 11'sd128; xa2 = cb - 11'sd128;
        ax0 = 11'sd128; xa0 = cr - 11'sd128;
        case (r_mode)
            M_CON_M, M_CON_Y, M_CON_C: xa0 = mn - 11'sd128;
            M_SAT_ALL, M_SAT_B, M_SAT_G, M_SAT_R: begin
                ax0 = av; xa0 = cr - av;
                ax1 = av; xa1 = cg - av;
                ax2 = av; xa2 = cb - av;
            end
            M_SAT_M, M_SAT_Y, M_SAT_C: begin ax0 = av; xa0 = mn - av; end
            M_BRIGHT, M_LUM_B, M_LUM_G, M_LUM_R, M_LUM_M, M_LUM_Y, M_LUM_C: begin
                ax0 = 11'sd0; xa0 = av;
            end
            default: ;
        endcase
        s0 = scaled(ax0, xa0, r_gain);
        s1 = scaled(ax1, xa1, r_gain);
        s2 = scaled(ax2, xa2, r_gain);

        // Brightness rule: c - avg + n, n from lane 0
        lum_r = NW'(cr - av) + s0;
        lum_g = NW'(cg - av) + s0;
        lum_b = NW'(cb - av) + s0;
        // Secondary saturation keeps the pair min unless it is at or above avg
        ms = (mn >= av) ? s0 : NW'(mn);

        n_out.red_out   = r_in.red;
        n_out.green_out = r_in.green;
        n_out.blue_out  = r_in.blue;
        n_out.alpha_out = r_in.alpha;

        case (r_mode)
            M_GREY: begin
                n_out.red_out = av[7:0]; n_out.green_out = av[7:0];
                n_out.blue_out = av[7:0];
            end
            M_BRIGHT: begin
                n_out.red_out = clamp8(lum_r); n_out.green_out = clamp8(lum_g);
                n_out.blue_out = clamp8(lum_b);
            end
            M_CON_ALL: begin
                n_out.red_out = clamp8(s0); n_out.green_out = clamp8(s1);
                n_out.blue_out = clamp8(s2);
            end
            M_CON_R: n_out.red_out   = clamp8(s0);
            M_CON_G: n_out.green_out = clamp8(s1);
            M_CON_B: n_out.blue_out  = clamp8(s2);
            M_CON_M, M_SAT_M: begin
                n_out.red_out  = clamp8((r_mode == M_CON_M ? s0 : ms) + NW'(cr - mn));
                n_out.blue_out = clamp8((r_mode == M_CON_M ? s0 : ms) + NW'(cb - mn));
            end
            M_CON_Y, M_SAT_Y: begin
                n_out.red_out   = clamp8((r_mode == M_CON_Y ? s0 : ms) + NW'(cr - mn));
                n_out.green_out = clamp8((r_mode == M_CON_Y ? s0 : ms) + NW'(cg - mn));
            end
            M_CON_C, M_SAT_C: begin
                n_out.green_out = clamp8((r_mode == M_CON_C ? s0 : ms) + NW'(cg - mn));
                n_out.blue_out  = clamp8((r_mode == M_CON_C ? s0 : ms) + NW'(cb - mn));
            end
            M_SAT_ALL: begin
                if (cr > av) n_out.red_out   = clamp8(s0);
                if (cg > av) n_out.green_out = clamp8(s1);
                if (cb > av) n_out.blue_out  = clamp8(s2);
            end
            M_SAT_B: if (dom_b) n_out.blue_out  = clamp8(s2);
            M_SAT_G: if (dom_g) n_out.green_out = clamp8(s1);
            M_SAT_R: if (dom_r) n_out.red_out   = clamp8(s0);
            M_LUM_B, M_LUM_G, M_LUM_R, M_LUM_M, M_LUM_Y, M_LUM_C: begin
                if ((r_mode == M_LUM_B && dom_b) || (r_mode == M_LUM_G && dom_g) ||
                    (r_mode == M_LUM_R && dom_r) ||
                    ((r_mode == M_LUM_M || r_mode == M_LUM_Y || r_mode == M_LUM_C)
                     && mn > av)) begin
                    n_out.red_out = clamp8(lum_r); n_out.green_out = clamp8(lum_g);
                    n_out.blue_out = clamp8(lum_b);
                end
            end
            default: ;
        endcase
    end

endmodule

>>> rtl/core/pca_checker.sv
// Port-level assertions for the pixel color adjust block, with its bind.
module pca_checker (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              o_stall,
    input logic              o_valid,
    input logic              i_stall,
    input pca_pkg::t_pix_out o_pix
);
    import pca_pkg::*;

    // Stall upstream only while a result waits and the output side stalls
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (o_valid && i_stall)) else $error("stall without full output");

    // Leave reset with no result pending
    a_reset_empty: assert property (@(posedge i_clk)
        (i_rst_n && $past(!i_rst_n)) |-> !o_valid) else $error("valid after reset");

    a_hold_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> o_valid) else $error("valid dropped under stall");

    a_hold_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> $stable(o_pix)) else $error("payload changed under stall");

endmodule

bind pixel_color_adjust pca_checker u_pca_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .o_stall (o_stall),
    .o_valid (o_valid),
    .i_stall (i_stall),
    .o_pix   (o_pix)
);
